// ===== hw/rtl/cpff_pkg.sv =====
// Shared constants and codes for the clamped pose fix fusion block.
package cpff_pkg;

  // Default datapath widths.
  localparam int unsigned DEF_POSITION_WIDTH = 32;
  localparam int unsigned DEF_ANGLE_WIDTH    = 16;

  // Fixed register and field widths.
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CONF_W     = 16;
  localparam int unsigned DIST_W     = 31;
  localparam int unsigned ANGSTEP_W  = 15;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FUSION_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONFIDENCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SHIFT_DIST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SHIFT_ANG  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FUSING_ENABLED = 3'd4;

  // Fusion modes.
  localparam logic [MODE_W-1:0] MODE_WHEEL   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VISION  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INSTANT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_GRADUAL = 2'd3;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_ODOM = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FIX  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TARE = 2'd2;

  // Last step counts of the root and the divide.
  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] DIV_LAST  = 5'd30;

endpackage

// ===== hw/rtl/clamped_pose_fix_fusion_unit.sv =====
// Pose keeper that fuses odometry ticks, tares and bounded vision fixes.
//
// Usage: each input word (valid/ready) is one request: an odometry tick, a
// vision fix or a tare. Each request yields exactly one output word
// (valid/ready) that carries the pose after the update and a retare flag.
// Configuration registers are written through cfg_we_i/cfg_index_i/
// cfg_data_i, one register per cycle; the user must write them only while
// the block is idle, which the block itself does not enforce. Ticks, tares,
// ignored and rejected fixes go from idle straight to the output state. An
// instant fix passes the difference and check states first; a gradual fix
// also scales down, squares and compares the offsets, and one that lands
// within max_shift_distance is copied. A gradual fix beyond it runs a 32-step
// square root and two 31-step divides on one shared subtractor, and the
// squares and products go through one shared 31x31 multiplier.
// The block takes one request at a time; in_ready_o is high while idle.
// The output word sits in a register, so a new request is accepted and
// worked on while the previous word waits; its result then holds until the
// receiver takes the earlier word.
// Reset (rst_ni low) clears the pose, the rejected flag and the output
// valid, and restores the registers to wheel-only mode with fusing enabled.
module clamped_pose_fix_fusion_unit
  import cpff_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = DEF_POSITION_WIDTH,
  parameter int unsigned ANGLE_WIDTH    = DEF_ANGLE_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [CFG_IDX_W-1:0]             cfg_index_i,
  input  logic [CFG_DATA_W-1:0]            cfg_data_i,
  // Request channel.
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [REQ_W-1:0]                 req_type_i,
  input  logic signed [POSITION_WIDTH-1:0] in_x_i,
  input  logic signed [POSITION_WIDTH-1:0] in_y_i,
  input  logic signed [POSITION_WIDTH-1:0] in_z_i,
  input  logic signed [ANGLE_WIDTH-1:0]    in_heading_i,
  input  logic signed [ANGLE_WIDTH-1:0]    in_roll_i,
  input  logic signed [ANGLE_WIDTH-1:0]    in_pitch_i,
  input  logic [CONF_W-1:0]                in_confidence_i,
  // Result channel.
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [POSITION_WIDTH-1:0] out_x_o,
  output logic signed [POSITION_WIDTH-1:0] out_y_o,
  output logic signed [POSITION_WIDTH-1:0] out_z_o,
  output logic signed [ANGLE_WIDTH-1:0]    out_heading_o,
  output logic signed [ANGLE_WIDTH-1:0]    out_roll_o,
  output logic signed [ANGLE_WIDTH-1:0]    out_pitch_o,
  output logic [CONF_W-1:0]                out_confidence_o,
  output logic                             frames_approved_o,
  output logic                             retare_odometry_o
);

  localparam int unsigned PW  = POSITION_WIDTH;
  localparam int unsigned AW  = ANGLE_WIDTH;
  localparam int unsigned DW  = PW + 1;
  localparam int unsigned SW  = (DW > 32) ? DW : 32;
  localparam int unsigned AMW = (AW > ANGSTEP_W) ? AW : ANGSTEP_W;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIFF  = 4'd1;
  localparam logic [3:0] ST_CHECK = 4'd2;
  localparam logic [3:0] ST_HALVE = 4'd3;
  localparam logic [3:0] ST_SQ1   = 4'd4;
  localparam logic [3:0] ST_SQ2   = 4'd5;
  localparam logic [3:0] ST_SQ3   = 4'd6;
  localparam logic [3:0] ST_SQ4   = 4'd7;
  localparam logic [3:0] ST_SQRT  = 4'd8;
  localparam logic [3:0] ST_MULD  = 4'd9;
  localparam logic [3:0] ST_LOADD = 4'd10;
  localparam logic [3:0] ST_DIV   = 4'd11;
  localparam logic [3:0] ST_APPLY = 4'd12;
  localparam logic [3:0] ST_EMIT  = 4'd13;

  logic [3:0]           state_q;

  // Configuration registers.
  logic [MODE_W-1:0]    mode_q;
  logic [CONF_W-1:0]    minc_q;
  logic [DIST_W-1:0]    maxd_q;
  logic [ANGSTEP_W-1:0] maxa_q;
  logic                 fuse_q;

  // Pose state.
  logic [PW-1:0]        pose_x_q, pose_y_q, pose_z_q;
  logic [AW-1:0]        pose_h_q, pose_roll_q, pose_pitch_q;
  logic [CONF_W-1:0]    pose_conf_q;
  logic                 fix_rejected_q;
  logic                 retare_q;

  // Datapath registers.
  logic [PW-1:0]        fx_q, fy_q;
  logic [AW-1:0]        fh_q;
  logic [DW-1:0]        dx_q, dy_q;
  logic [SW-1:0]        sx_q, sy_q;
  logic                 big_q;
  logic                 axis_q;
  logic [61:0]          prod_q;
  logic [63:0]          acc_q;
  logic [33:0]          rem_q;
  logic [31:0]          root_q;
  logic [31:0]          norm_q;
  logic [DIST_W-1:0]    quo_q;
  logic [DIST_W-1:0]    low_q;
  logic [4:0]           cnt_q;

  // Output register.
  logic                 out_valid_q;
  logic [PW-1:0]        out_x_q, out_y_q, out_z_q;
  logic [AW-1:0]        out_h_q, out_roll_q, out_pitch_q;
  logic [CONF_W-1:0]    out_conf_q;
  logic                 out_appr_q, out_retare_q;

  // Combinational datapath signals.
  logic                 gradual;
  logic                 emit_load;
  logic [DW-1:0]        dx_d, dy_d, ax, ay;
  logic                 big;
  logic                 need_halve;
  logic                 far;
  logic [DIST_W-1:0]    mul_a, mul_b;
  logic [61:0]          prod_d;
  logic [34:0]          sub_a, sub_b;
  logic [35:0]          sub_diff;
  logic                 sub_ge;
  logic [33:0]          rem_next;
  logic [31:0]          root_next;
  logic [AW-1:0]        dh, dh_mag, ang_step, ang_adj;
  logic [AMW-1:0]       ang_lim;
  logic                 ang_over;
  logic [DW-1:0]        full;
  logic                 step_neg;
  logic [SW-1:0]        step;
  logic [PW-1:0]        step_p, step_adj;

  assign gradual    = (mode_q == MODE_GRADUAL);
  assign in_ready_o = (state_q == ST_IDLE);
  assign emit_load  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // Position differences and their magnitudes.
  assign dx_d = {fx_q[PW-1], fx_q} - {pose_x_q[PW-1], pose_x_q};
  assign dy_d = {fy_q[PW-1], fy_q} - {pose_y_q[PW-1], pose_y_q};
  assign ax   = dx_q[DW-1] ? (~dx_q + DW'(1)) : dx_q;
  assign ay   = dy_q[DW-1] ? (~dy_q + DW'(1)) : dy_q;
  assign big  = (SW'(ax) > SW'(maxd_q)) || (SW'(ay) > SW'(maxd_q));

  // Both scaled magnitudes must fit 31 bits before squaring.
  assign need_halve = (sx_q[SW-1:31] != '0) || (sy_q[SW-1:31] != '0);
  assign far        = big_q || (acc_q > 64'(prod_q));

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = sx_q[DIST_W-1:0];
    mul_b = sx_q[DIST_W-1:0];
    unique case (state_q)
      ST_SQ2: begin
        mul_a = sy_q[DIST_W-1:0];
        mul_b = sy_q[DIST_W-1:0];
      end
      ST_SQ3: begin
        mul_a = maxd_q;
        mul_b = maxd_q;
      end
      ST_MULD: begin
        mul_a = maxd_q;
        mul_b = axis_q ? sy_q[DIST_W-1:0] : sx_q[DIST_W-1:0];
      end
      default: begin
        mul_a = sx_q[DIST_W-1:0];
        mul_b = sx_q[DIST_W-1:0];
      end
    endcase
  end

  assign prod_d = 62'(mul_a) * 62'(mul_b);

  // Shared subtractor: root digit trial or divide step.
  always_comb begin
    if (state_q == ST_SQRT) begin
      sub_a = {rem_q[32:0], acc_q[63:62]};
      sub_b = {1'b0, root_q, 2'b01};
    end else begin
      sub_a = {2'b00, rem_q[31:0], low_q[DIST_W-1]};
      sub_b = {3'b000, norm_q};
    end
  end

  assign sub_diff  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge    = !sub_diff[35];
  assign rem_next  = sub_ge ? sub_diff[33:0] : sub_a[33:0];
  assign root_next = {root_q[30:0], sub_ge};

  // Heading difference, wrapped, and the bounded heading step.
  assign dh       = fh_q - pose_h_q;
  assign dh_mag   = dh[AW-1] ? (~dh + AW'(1)) : dh;
  assign ang_lim  = AMW'(maxa_q);
  assign ang_over = (AMW'(dh_mag) > ang_lim);
  assign ang_step = AW'(ang_lim);
  assign ang_adj  = dh[AW-1] ? (~ang_step + AW'(1)) : ang_step;

  // Position step: the quotient, capped at the full distance on that axis.
  assign full     = axis_q ? ay : ax;
  assign step_neg = axis_q ? dy_q[DW-1] : dx_q[DW-1];
  assign step     = (SW'(quo_q) > SW'(full)) ? SW'(full) : SW'(quo_q);
  assign step_p   = PW'(step);
  assign step_adj = step_neg ? (~step_p + PW'(1)) : step_p;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_WHEEL;
      minc_q <= '0;
      maxd_q <= '0;
      maxa_q <= '0;
      fuse_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FUSION_MODE:    mode_q <= cfg_data_i[MODE_W-1:0];
        CFG_MIN_CONFIDENCE: minc_q <= cfg_data_i[CONF_W-1:0];
        CFG_MAX_SHIFT_DIST: maxd_q <= cfg_data_i[DIST_W-1:0];
        CFG_MAX_SHIFT_ANG:  maxa_q <= cfg_data_i[ANGSTEP_W-1:0];
        CFG_FUSING_ENABLED: fuse_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer and pose state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      pose_x_q       <= '0;
      pose_y_q       <= '0;
      pose_z_q       <= '0;
      pose_h_q       <= '0;
      pose_roll_q    <= '0;
      pose_pitch_q   <= '0;
      pose_conf_q    <= '0;
      fix_rejected_q <= 1'b0;
      retare_q       <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            retare_q <= 1'b0;
            state_q  <= ST_EMIT;
            unique case (req_type_i)
              REQ_ODOM: begin
                if (mode_q != MODE_VISION) begin
                  pose_x_q <= in_x_i;
                  pose_y_q <= in_y_i;
                  pose_h_q <= in_heading_i;
                end
                pose_roll_q  <= in_roll_i;
                pose_pitch_q <= in_pitch_i;
              end
              REQ_FIX: begin
                if ((mode_q != MODE_WHEEL) && fuse_q) begin
                  pose_z_q    <= in_z_i;
                  pose_conf_q <= in_confidence_i;
                  if (in_confidence_i >= minc_q) begin
                    fix_rejected_q <= 1'b0;
                    retare_q       <= 1'b1;
                    state_q        <= ST_DIFF;
                  end else begin
                    fix_rejected_q <= 1'b1;
                  end
                end
              end
              REQ_TARE: begin
                pose_x_q <= in_x_i;
                pose_y_q <= in_y_i;
                pose_z_q <= in_z_i;
                pose_h_q <= in_heading_i;
                retare_q <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        // Heading settles here; position differences are registered.
        ST_DIFF: begin
          if (gradual && ang_over) begin
            pose_h_q <= pose_h_q + ang_adj;
          end else begin
            pose_h_q <= fh_q;
          end
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!gradual) begin
            pose_x_q <= fx_q;
            pose_y_q <= fy_q;
            state_q  <= ST_EMIT;
          end else begin
            state_q <= ST_HALVE;
          end
        end
        ST_HALVE: begin
          if (!need_halve) begin
            state_q <= ST_SQ1;
          end
        end
        ST_SQ1: state_q <= ST_SQ2;
        ST_SQ2: state_q <= ST_SQ3;
        ST_SQ3: state_q <= ST_SQ4;
        // Within the step limit the fix is copied.
        ST_SQ4: begin
          if (far) begin
            state_q <= ST_SQRT;
          end else begin
            pose_x_q <= fx_q;
            pose_y_q <= fy_q;
            state_q  <= ST_EMIT;
          end
        end
        ST_SQRT: begin
          if (cnt_q == '0) begin
            state_q <= (root_next == '0) ? ST_EMIT : ST_MULD;
          end
        end
        ST_MULD:  state_q <= ST_LOADD;
        ST_LOADD: state_q <= ST_DIV;
        ST_DIV: begin
          if (cnt_q == '0) begin
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (axis_q) begin
            pose_y_q <= pose_y_q + step_adj;
            state_q  <= ST_EMIT;
          end else begin
            pose_x_q <= pose_x_q + step_adj;
            state_q  <= ST_MULD;
          end
        end
        ST_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Iteration registers of the shared units.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          fx_q <= in_x_i;
          fy_q <= in_y_i;
          fh_q <= in_heading_i;
        end
      end
      ST_DIFF: begin
        dx_q <= dx_d;
        dy_q <= dy_d;
      end
      ST_CHECK: begin
        sx_q   <= SW'(ax);
        sy_q   <= SW'(ay);
        big_q  <= big;
        axis_q <= 1'b0;
      end
      ST_HALVE: begin
        if (need_halve) begin
          sx_q <= sx_q >> 1;
          sy_q <= sy_q >> 1;
        end
      end
      ST_SQ2: acc_q <= 64'(prod_q);
      ST_SQ3: acc_q <= acc_q + 64'(prod_q);
      ST_SQ4: begin
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= SQRT_LAST;
      end
      // One root digit per cycle, two radicand bits at a time.
      ST_SQRT: begin
        rem_q  <= rem_next;
        root_q <= root_next;
        acc_q  <= acc_q << 2;
        cnt_q  <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          norm_q <= root_next;
        end
      end
      // The quotient fits 31 bits, so the upper half starts as remainder.
      ST_LOADD: begin
        rem_q <= 34'(prod_q[61:DIST_W]);
        low_q <= prod_q[DIST_W-1:0];
        quo_q <= '0;
        cnt_q <= DIV_LAST;
      end
      ST_DIV: begin
        rem_q <= rem_next;
        quo_q <= {quo_q[DIST_W-2:0], sub_ge};
        low_q <= low_q << 1;
        cnt_q <= cnt_q - 5'd1;
      end
      ST_APPLY: axis_q <= 1'b1;
      default: ;
    endcase
  end

  // Output word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_x_q      <= pose_x_q;
      out_y_q      <= pose_y_q;
      out_z_q      <= pose_z_q;
      out_h_q      <= pose_h_q;
      out_roll_q   <= pose_roll_q;
      out_pitch_q  <= pose_pitch_q;
      out_conf_q   <= pose_conf_q;
      out_appr_q   <= !fix_rejected_q;
      out_retare_q <= retare_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_x_o           = out_x_q;
  assign out_y_o           = out_y_q;
  assign out_z_o           = out_z_q;
  assign out_heading_o     = out_h_q;
  assign out_roll_o        = out_roll_q;
  assign out_pitch_o       = out_pitch_q;
  assign out_confidence_o  = out_conf_q;
  assign frames_approved_o = out_appr_q;
  assign retare_odometry_o = out_retare_q;

`ifndef SYNTHESIS
  // Only one request is in the sequencer at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in progress");

  // The divide remainder never reaches the root it divides by.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> ((rem_q[33:32] == 2'b00) && (rem_q[31:0] < norm_q)))
    else $error("divide remainder out of range");

  // A bounded step never exceeds the configured distance limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) |-> (quo_q <= maxd_q))
    else $error("position step above max shift distance");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the clamped pose fix fusion unit.
module tb;
  import cpff_pkg::*;

  localparam int unsigned POS_W = DEF_POSITION_WIDTH;
  localparam int unsigned ANG_W = DEF_ANGLE_WIDTH;

  // The request code that the block answers without any change.
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [ANG_W-1:0] ANG_MIN = {1'b1, {(ANG_W-1){1'b0}}};
  localparam logic signed [ANG_W-1:0] ANG_MAX = {1'b0, {(ANG_W-1){1'b1}}};
  localparam int ONE_METER = 1 << 16;

  localparam bit [63:0] HALVE_LIMIT    = 64'd1 << 31;
  localparam int        PHASES         = 10;
  localparam int        PHASE_WORDS    = 125;
  localparam int        HOLD_AT        = 330;
  localparam int        HOLD_CYCLES    = 300;
  localparam int        TIMEOUT_CYCLES = 1000000;

  typedef struct {
    logic [REQ_W-1:0]         kind;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [POS_W-1:0]  z;
    logic signed [ANG_W-1:0]  heading;
    logic signed [ANG_W-1:0]  roll;
    logic signed [ANG_W-1:0]  pitch;
    logic [CONF_W-1:0]        conf;
  } fusion_req_t;

  typedef struct {
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [POS_W-1:0]  z;
    logic signed [ANG_W-1:0]  heading;
    logic signed [ANG_W-1:0]  roll;
    logic signed [ANG_W-1:0]  pitch;
    logic [CONF_W-1:0]        conf;
    logic                     approved;
    logic                     retare;
  } pose_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;

  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  fusion_req_t             cur_req = '{default: '0};
  logic [REQ_W-1:0]        req_type_i;
  logic signed [POS_W-1:0] in_x_i, in_y_i, in_z_i;
  logic signed [ANG_W-1:0] in_heading_i, in_roll_i, in_pitch_i;
  logic [CONF_W-1:0]       in_confidence_i;

  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [POS_W-1:0] out_x_o, out_y_o, out_z_o;
  logic signed [ANG_W-1:0] out_heading_o, out_roll_o, out_pitch_o;
  logic [CONF_W-1:0]       out_confidence_o;
  logic                    frames_approved_o;
  logic                    retare_odometry_o;

  // Register copies and pose state kept by the predictor.
  logic [MODE_W-1:0]       mode_q = MODE_WHEEL;
  logic [CONF_W-1:0]       min_conf_q = '0;
  logic [DIST_W-1:0]       dist_q = '0;
  logic [ANGSTEP_W-1:0]    ang_q = '0;
  logic                    fuse_en_q = 1'b1;
  logic signed [POS_W-1:0] px = '0, py = '0, pz = '0;
  logic signed [ANG_W-1:0] ph = '0, proll = '0, ppitch = '0;
  logic [CONF_W-1:0]       pconf = '0;
  logic                    rejected = 1'b0;

  fusion_req_t pending[$];
  pose_word_t  pose_due[$];

  bit in_fire = 1'b0;
  bit quiet = 1'b0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_bad = 0;
  int kind_seen[4] = '{0, 0, 0, 0};
  int n_rejected = 0;
  int n_ignored = 0;
  int n_clamped = 0;
  int send_gap = 0;
  int sink_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  assign req_type_i      = cur_req.kind;
  assign in_x_i          = cur_req.x;
  assign in_y_i          = cur_req.y;
  assign in_z_i          = cur_req.z;
  assign in_heading_i    = cur_req.heading;
  assign in_roll_i       = cur_req.roll;
  assign in_pitch_i      = cur_req.pitch;
  assign in_confidence_i = cur_req.conf;

  clamped_pose_fix_fusion_unit i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .in_x_i            (in_x_i),
    .in_y_i            (in_y_i),
    .in_z_i            (in_z_i),
    .in_heading_i      (in_heading_i),
    .in_roll_i         (in_roll_i),
    .in_pitch_i        (in_pitch_i),
    .in_confidence_i   (in_confidence_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_x_o           (out_x_o),
    .out_y_o           (out_y_o),
    .out_z_o           (out_z_o),
    .out_heading_o     (out_heading_o),
    .out_roll_o        (out_roll_o),
    .out_pitch_o       (out_pitch_o),
    .out_confidence_o  (out_confidence_o),
    .frames_approved_o (frames_approved_o),
    .retare_odometry_o (retare_odometry_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Floor square root, one result bit per pass.
  function automatic bit [63:0] int_root(bit [63:0] n);
    bit [63:0] res;
    bit [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // One axis of a bounded move: the share m*|d|/norm, never past the fix.
  function automatic longint clamp_step(longint d, bit [63:0] scaled, bit [63:0] norm,
                                        bit [63:0] m);
    bit [63:0] full;
    bit [63:0] s;
    full = (d < 0) ? -d : d;
    s = m * scaled / norm;
    if (s > full) s = full;
    return (d < 0) ? -longint'(s) : longint'(s);
  endfunction

  // Applies one request to the predicted pose and returns the word it answers.
  function automatic pose_word_t fuse_request(fusion_req_t r);
    longint dx, dy;
    bit [63:0] ax, ay, sx, sy, m, norm;
    logic signed [ANG_W-1:0] dh;
    int dmag;
    bit far;
    bit retare;
    pose_word_t w;
    retare = 1'b0;
    kind_seen[r.kind]++;
    case (r.kind)
      REQ_ODOM: begin
        if (mode_q != MODE_VISION) begin
          px = r.x;
          py = r.y;
          ph = r.heading;
        end
        proll = r.roll;
        ppitch = r.pitch;
      end
      REQ_FIX: begin
        if (mode_q == MODE_WHEEL || !fuse_en_q) begin
          n_ignored++;
        end else begin
          if (r.conf >= min_conf_q) begin
            rejected = 1'b0;
            retare = 1'b1;
            dx = longint'(r.x) - longint'(px);
            dy = longint'(r.y) - longint'(py);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            m = dist_q;
            if (ax > m || ay > m) far = 1'b1;
            else far = (ax * ax + ay * ay) > (m * m);
            if (mode_q == MODE_GRADUAL && far) begin
              // Scale both offsets down together so the squares fit.
              sx = ax;
              sy = ay;
              while (sx >= HALVE_LIMIT || sy >= HALVE_LIMIT) begin
                sx = sx >> 1;
                sy = sy >> 1;
              end
              norm = int_root(sx * sx + sy * sy);
              if (norm != 0) begin
                px = longint'(px) + clamp_step(dx, sx, norm, m);
                py = longint'(py) + clamp_step(dy, sy, norm, m);
              end
              n_clamped++;
            end else begin
              px = r.x;
              py = r.y;
            end
            // In gradual mode the heading turns by at most the angle step, wrapping around.
            dh = r.heading - ph;
            dmag = (dh < 0) ? -int'(dh) : int'(dh);
            if (mode_q == MODE_GRADUAL && dmag > int'(ang_q)) begin
              ph = int'(ph) + ((dh < 0) ? -int'(ang_q) : int'(ang_q));
            end else begin
              ph = r.heading;
            end
          end else begin
            rejected = 1'b1;
            n_rejected++;
          end
          pz = r.z;
          pconf = r.conf;
        end
      end
      REQ_TARE: begin
        px = r.x;
        py = r.y;
        pz = r.z;
        ph = r.heading;
        retare = 1'b1;
      end
      default: ;
    endcase
    w.x = px;
    w.y = py;
    w.z = pz;
    w.heading = ph;
    w.roll = proll;
    w.pitch = ppitch;
    w.conf = pconf;
    w.approved = !rejected;
    w.retare = retare;
    return w;
  endfunction

  function automatic string pose_str(pose_word_t w);
    return $sformatf("x=%0d y=%0d z=%0d hd=%0d roll=%0d pitch=%0d conf=%0d ok=%0b retare=%0b",
                     w.x, w.y, w.z, w.heading, w.roll, w.pitch, w.conf, w.approved, w.retare);
  endfunction

  // Positions are either fully random or small offsets of random scale.
  function automatic logic signed [POS_W-1:0] random_position();
    logic [31:0] v;
    if ($urandom_range(0, 3) == 0) return $urandom();
    v = $urandom() >> (32 - $urandom_range(4, 26));
    return ($urandom_range(0, 1) != 0) ? -int'(v) : int'(v);
  endfunction

  function automatic logic signed [ANG_W-1:0] random_angle();
    logic [31:0] v;
    if ($urandom_range(0, 1) == 0) return $urandom();
    v = $urandom() >> (32 - $urandom_range(2, 14));
    return ($urandom_range(0, 1) != 0) ? -int'(v) : int'(v);
  endfunction

  // Confidence is drawn around the current threshold half of the time.
  function automatic logic [CONF_W-1:0] random_confidence();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return min_conf_q;
      3: return min_conf_q - 1'b1;
      4: return min_conf_q + 1'b1;
      default: return $urandom();
    endcase
  endfunction

  function automatic fusion_req_t random_request();
    fusion_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) r.kind = REQ_ODOM;
    else if (pick < 80) r.kind = REQ_FIX;
    else if (pick < 94) r.kind = REQ_TARE;
    else r.kind = REQ_NONE;
    r.x = random_position();
    r.y = random_position();
    r.z = $urandom();
    r.heading = random_angle();
    r.roll = $urandom();
    r.pitch = $urandom();
    r.conf = random_confidence();
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] random_distance();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return $urandom() >> $urandom_range(1, 31);
    endcase
  endfunction

  function automatic logic [ANGSTEP_W-1:0] random_turn();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 32767);
    return $urandom_range(0, 2000);
  endfunction

  function automatic logic [CONF_W-1:0] random_threshold();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $urandom_range(0, 4096);
  endfunction

  // Queues one request; called right after a rising edge.
  task automatic push_req(logic [REQ_W-1:0] kind, logic signed [POS_W-1:0] x,
                          logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z,
                          logic signed [ANG_W-1:0] hd, logic signed [ANG_W-1:0] roll,
                          logic signed [ANG_W-1:0] pitch, logic [CONF_W-1:0] conf);
    fusion_req_t r;
    r.kind = kind;
    r.x = x;
    r.y = y;
    r.z = z;
    r.heading = hd;
    r.roll = roll;
    r.pitch = pitch;
    r.conf = conf;
    pending.push_back(r);
    n_queued++;
  endtask

  // Waits until every queued request has answered.
  task automatic drain();
    while (n_checked != n_queued) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
  endtask

  // Writes all five registers; the block is idle whenever this runs.
  task automatic set_config(logic [MODE_W-1:0] mode, logic [CONF_W-1:0] conf,
                            logic [DIST_W-1:0] shift_dist, logic [ANGSTEP_W-1:0] ang,
                            logic en);
    write_reg(CFG_FUSION_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_MIN_CONFIDENCE, CFG_DATA_W'(conf));
    write_reg(CFG_MAX_SHIFT_DIST, CFG_DATA_W'(shift_dist));
    write_reg(CFG_MAX_SHIFT_ANG, CFG_DATA_W'(ang));
    write_reg(CFG_FUSING_ENABLED, CFG_DATA_W'(en));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = mode;
    min_conf_q = conf;
    dist_q = shift_dist;
    ang_q = ang;
    fuse_en_q = en;
    @(posedge clk_i);
  endtask

  // Request driver: holds a word until it is taken, with random idle bursts.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid_i || in_fire) begin
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_valid_i <= 1'b0;
        send_gap <= $urandom_range(0, 18);
      end else if (pending.size() != 0) begin
        cur_req <= pending.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: random stall bursts plus one long hold-off.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_gap <= 0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
    end else if (sink_gap != 0) begin
      out_ready_i <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      sink_gap <= $urandom_range(0, 18);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // The long hold-off starts once, partway into the random part.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each result word, then predicts for each accepted request.
  always @(posedge clk_i) begin : pose_monitor
    pose_word_t got;
    pose_word_t want;
    bit bad;
    in_fire <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.x = out_x_o;
        got.y = out_y_o;
        got.z = out_z_o;
        got.heading = out_heading_o;
        got.roll = out_roll_o;
        got.pitch = out_pitch_o;
        got.conf = out_confidence_o;
        got.approved = frames_approved_o;
        got.retare = retare_odometry_o;
        if (pose_due.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("Unexpected result word: %s", pose_str(got));
        end else begin
          want = pose_due.pop_front();
          bad = (got.x !== want.x) || (got.y !== want.y) || (got.z !== want.z) ||
                (got.heading !== want.heading) || (got.roll !== want.roll) ||
                (got.pitch !== want.pitch) || (got.conf !== want.conf) ||
                (got.approved !== want.approved) || (got.retare !== want.retare);
          if (bad) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("Mismatch on word %0d: expected %s", n_checked, pose_str(want));
              $display("  actual %s", pose_str(got));
            end
          end
          n_checked <= n_checked + 1;
        end
      end
      if (in_valid_i && in_ready_o) begin
        pose_due.push_back(fuse_request(cur_req));
        n_accepted <= n_accepted + 1;
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Reset settings: wheel only, so fixes are ignored; unknown kind too.
    push_req(REQ_ODOM, POS_MIN, POS_MAX, 0, ANG_MIN, ANG_MAX, ANG_MIN, 0);
    push_req(REQ_FIX, 1, 1, 5, 7, 0, 0, '1);
    push_req(REQ_TARE, POS_MAX, POS_MIN, POS_MIN, ANG_MAX, 0, 0, 0);
    push_req(REQ_NONE, -1, -1, -1, -1, -1, -1, '1);
    drain();

    // Instant mode: confidence just below, at and above the threshold.
    set_config(MODE_INSTANT, 16'h8000, '0, '0, 1'b1);
    push_req(REQ_FIX, 9, 9, POS_MAX, 9, 0, 0, 16'h7FFF);
    push_req(REQ_FIX, 123 * ONE_METER, -5 * ONE_METER, 3, 1000, 0, 0, 16'h8000);
    push_req(REQ_FIX, POS_MIN, POS_MAX, POS_MIN, ANG_MIN, 0, 0, '1);
    drain();

    // Vision only: ticks carry only roll and pitch.
    set_config(MODE_VISION, '0, '0, '0, 1'b1);
    push_req(REQ_ODOM, 77, 88, 99, 111, -222, 333, 0);
    push_req(REQ_FIX, -4, 4, -4, -4, 0, 0, 0);
    drain();

    // Fusing switched off: the fix changes nothing.
    set_config(MODE_INSTANT, '0, '0, '0, 1'b0);
    push_req(REQ_FIX, 1000, 2000, 3000, 400, 0, 0, '1);
    drain();

    // Gradual mode with a one-meter step and a small turn limit.
    set_config(MODE_GRADUAL, '0, 31'(ONE_METER), 15'd100, 1'b1);
    push_req(REQ_TARE, 0, 0, 0, 0, 0, 0, 0);
    push_req(REQ_FIX, 10 * ONE_METER, 0, 1, 5000, 0, 0, 16'h1234);
    push_req(REQ_FIX, ONE_METER + 100, 200, 2, 50, 0, 0, 16'h1234);
    push_req(REQ_TARE, POS_MIN, POS_MIN, 0, 0, 0, 0, 0);
    push_req(REQ_FIX, POS_MAX, POS_MAX, 3, ANG_MIN, 0, 0, 16'h1234);
    push_req(REQ_FIX, POS_MIN, 0, 4, 0, 0, 0, 16'h1234);
    drain();

    // Widest step and turn with the strictest threshold.
    set_config(MODE_GRADUAL, '1, '1, '1, 1'b1);
    push_req(REQ_FIX, 5, 5, 5, 5, 0, 0, 16'hFFFE);
    push_req(REQ_TARE, POS_MIN, POS_MIN, 0, ANG_MAX, 0, 0, 0);
    push_req(REQ_FIX, POS_MAX, POS_MAX, 6, ANG_MIN, 0, 0, '1);
    push_req(REQ_FIX, 12345, -6789, 7, 0, 0, 0, '1);
    drain();

    // A zero step: far fixes do not move the position or the heading.
    set_config(MODE_GRADUAL, '0, '0, '0, 1'b1);
    push_req(REQ_FIX, 5, -7, 8, 3, 0, 0, 0);
    drain();

    // Random phases over several register settings.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(MODE_GRADUAL, '0, '1, '1, 1'b1);
        1: set_config(MODE_GRADUAL, random_threshold(), '0, '0, 1'b1);
        2: set_config(MODE_INSTANT, '1, random_distance(), random_turn(), 1'b1);
        3: set_config(MODE_VISION, random_threshold(), random_distance(), random_turn(), 1'b1);
        4: set_config(MODE_WHEEL, random_threshold(), random_distance(), random_turn(), 1'b1);
        5: set_config(MODE_GRADUAL, random_threshold(), random_distance(), random_turn(), 1'b0);
        7: set_config(MODE_INSTANT, random_threshold(), random_distance(), random_turn(), 1'b1);
        default: set_config(MODE_GRADUAL, random_threshold(), random_distance(), random_turn(),
                            1'b1);
      endcase
      if (p == PHASES - 1) quiet = 1'b1;
      repeat (PHASE_WORDS) begin
        pending.push_back(random_request());
        n_queued++;
      end
      drain();
    end

    // Let any stray word show up before the verdict.
    repeat (120) @(negedge clk_i);
    $display("Covered %0d requests: %0d ticks, %0d fixes, %0d tares, %0d of unknown kind.",
             n_checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    $display("Fixes: %0d rejected, %0d ignored, %0d bounded gradual moves; %0d bad words.",
             n_rejected, n_ignored, n_clamped, n_bad);
    if (n_bad == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 12);
    $display("Timeout: %0d of %0d words checked.", n_checked, n_queued);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== clamped_pose_fix_fusion_unit.f =====
hw/rtl/cpff_pkg.sv
hw/rtl/clamped_pose_fix_fusion_unit.sv
tb/tb.sv
